// ===== design/pcss_pkg.sv =====
// Shared types, codes and word builders for the PCI config space scan sequencer.
`default_nettype none

package pcss_pkg;

   localparam int NUM_BUSES_DEFAULT       = 256;
   localparam int DEVICES_PER_BUS_DEFAULT = 32;
   localparam int MULTI_FUNCTIONS_DEFAULT = 8;

   localparam int RSP_DEPTH = 4;

   // input word mode
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   // result kinds
   localparam logic [2:0] KIND_REQUEST   = 3'd0;
   localparam logic [2:0] KIND_REPORT    = 3'd1;
   localparam logic [2:0] KIND_FOUND     = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;

   // register offsets requested
   localparam logic [7:0] OFFSET_ID     = 8'h00;
   localparam logic [7:0] OFFSET_CLASS  = 8'h08;
   localparam logic [7:0] OFFSET_HEADER = 8'h0C;

   localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
   localparam int          MULTI_BIT     = 23;  // header type bit 7 in the returned dword

   // csr indexes
   localparam logic [1:0] CSR_SCAN_MODE     = 2'd0;
   localparam logic [1:0] CSR_TARGET_VENDOR = 2'd1;
   localparam logic [1:0] CSR_TARGET_DEVICE = 2'd2;

   typedef enum logic [2:0] {
      PHASE_IDLE,
      PHASE_PROBE,
      PHASE_HEADER,
      PHASE_FUNC,
      PHASE_CLASS
   } phase_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] read_data;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  bus_number;
      logic [4:0]  device_number;
      logic [2:0]  function_number;
      logic [7:0]  register_offset;
      logic [31:0] pci_address;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [7:0]  class_code;
      logic [7:0]  subclass_code;
      logic [16:0] device_count;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic        scan_mode;
      logic [15:0] target_vendor;
      logic [15:0] target_device;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  cur_bus;
      logic [4:0]  cur_device;
      logic [2:0]  cur_function;
      logic [3:0]  function_limit;
      logic [15:0] held_vendor;
      logic [15:0] held_device;
      logic [16:0] found_count;
   } scan_state_type;

   // up to two result words pushed per accepted input word
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word_a;
      rsp_word_type word_b;
   } push_type;

   function automatic rsp_word_type make_request(input logic [7:0] bus,
                                                 input logic [4:0] dev,
                                                 input logic [2:0] func,
                                                 input logic [7:0] offset);
      rsp_word_type w;
      w                 = '0;
      w.kind            = KIND_REQUEST;
      w.bus_number      = bus;
      w.device_number   = dev;
      w.function_number = func;
      w.register_offset = offset;
      w.pci_address     = {1'b1, 7'd0, bus, dev, func, offset[7:2], 2'b00};
      return w;
   endfunction

   function automatic rsp_word_type make_simple(input logic [2:0] kind);
      rsp_word_type w;
      w      = '0;
      w.kind = kind;
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== design/pcss_step.sv =====
// Per-word scan step: next scan state and the result words one input word causes.
`default_nettype none

module pcss_step #(
   parameter int NUM_BUSES       = pcss_pkg::NUM_BUSES_DEFAULT,
   parameter int DEVICES_PER_BUS = pcss_pkg::DEVICES_PER_BUS_DEFAULT,
   parameter int MULTI_FUNCTIONS = pcss_pkg::MULTI_FUNCTIONS_DEFAULT
) (
   input  wire                       fire,
   input  pcss_pkg::req_word_type    word,
   input  pcss_pkg::cfg_type         cfg,
   input  pcss_pkg::scan_state_type  state,
   output pcss_pkg::scan_state_type  state_next,
   output pcss_pkg::push_type        push
);
   import pcss_pkg::*;

   logic [15:0]  ven;
   logic [15:0]  dev;
   logic         absent;
   logic         match;
   logic         start;
   logic         func_more;
   logic         dev_more;
   logic         bus_more;
   logic [16:0]  count_next;
   logic [7:0]   adv_bus;
   logic [4:0]   adv_dev;
   logic [2:0]   adv_func;
   phase_type    adv_phase;
   logic         adv_end;
   rsp_word_type adv_rsp;
   rsp_word_type word_a;
   rsp_word_type word_b;
   logic [1:0]   n_words;

   assign ven    = word.read_data[15:0];
   assign dev    = word.read_data[31:16];
   assign absent = (ven == VENDOR_ABSENT);
   assign match  = (ven == cfg.target_vendor) && (dev == cfg.target_device);
   assign start  = (word.mode == MODE_START);

   assign func_more = ({1'b0, state.cur_function} + 4'd1) < state.function_limit;
   assign dev_more  = ({1'b0, state.cur_device} + 6'd1) < 6'(DEVICES_PER_BUS);
   assign bus_more  = ({1'b0, state.cur_bus} + 9'd1) < 9'(NUM_BUSES);

   always_comb begin
      count_next = state.found_count;
      if (fire) begin
         if (start) begin
            count_next = '0;
         end else if (state.phase == PHASE_CLASS && state.found_count != '1) begin
            count_next = state.found_count + 17'd1;
         end
      end
   end

   // step to next function (not from probe), next device, next bus, or end
   always_comb begin
      adv_bus   = state.cur_bus;
      adv_dev   = state.cur_device;
      adv_func  = '0;
      adv_phase = PHASE_PROBE;
      adv_end   = 1'b0;
      priority if (state.phase != PHASE_PROBE && func_more) begin
         adv_func  = state.cur_function + 3'd1;
         adv_phase = PHASE_FUNC;
      end else if (dev_more) begin
         adv_dev = state.cur_device + 5'd1;
      end else if (bus_more) begin
         adv_dev = '0;
         adv_bus = state.cur_bus + 8'd1;
      end else begin
         adv_dev   = '0;
         adv_bus   = '0;
         adv_phase = PHASE_IDLE;
         adv_end   = 1'b1;
      end
   end

   assign adv_rsp = adv_end ? make_simple(cfg.scan_mode ? KIND_DONE : KIND_NOT_FOUND)
                            : make_request(adv_bus, adv_dev, adv_func, OFFSET_ID);

   // next state
   always_comb begin
      state_next = state;
      if (fire) begin
         if (start) begin
            state_next.phase          = PHASE_PROBE;
            state_next.cur_bus        = '0;
            state_next.cur_device     = '0;
            state_next.cur_function   = '0;
            state_next.function_limit = 4'd1;
         end else begin
            unique case (state.phase)
               PHASE_PROBE: begin
                  if (absent) begin
                     state_next.phase        = adv_phase;
                     state_next.cur_bus      = adv_bus;
                     state_next.cur_device   = adv_dev;
                     state_next.cur_function = adv_func;
                  end else begin
                     state_next.phase = PHASE_HEADER;
                  end
               end
               PHASE_HEADER: begin
                  state_next.function_limit = word.read_data[MULTI_BIT] ?
                                              4'(MULTI_FUNCTIONS) : 4'd1;
                  state_next.cur_function   = '0;
                  state_next.phase          = PHASE_FUNC;
               end
               PHASE_FUNC: begin
                  if (!cfg.scan_mode && match) begin
                     state_next.phase = PHASE_IDLE;
                  end else if (cfg.scan_mode && !absent) begin
                     state_next.held_vendor = ven;
                     state_next.held_device = dev;
                     state_next.phase       = PHASE_CLASS;
                  end else begin
                     state_next.phase        = adv_phase;
                     state_next.cur_bus      = adv_bus;
                     state_next.cur_device   = adv_dev;
                     state_next.cur_function = adv_func;
                  end
               end
               PHASE_CLASS: begin
                  state_next.phase        = adv_phase;
                  state_next.cur_bus      = adv_bus;
                  state_next.cur_device   = adv_dev;
                  state_next.cur_function = adv_func;
               end
               default: begin
               end
            endcase
         end
      end
      state_next.found_count = count_next;
   end

   // result words
   always_comb begin
      word_a  = '0;
      word_b  = '0;
      n_words = 2'd0;
      if (fire) begin
         if (start) begin
            word_a  = make_request('0, '0, '0, OFFSET_ID);
            n_words = 2'd1;
         end else begin
            unique case (state.phase)
               PHASE_PROBE: begin
                  word_a  = absent ? adv_rsp
                                   : make_request(state.cur_bus, state.cur_device,
                                                  state.cur_function, OFFSET_HEADER);
                  n_words = 2'd1;
               end
               PHASE_HEADER: begin
                  word_a  = make_request(state.cur_bus, state.cur_device, '0, OFFSET_ID);
                  n_words = 2'd1;
               end
               PHASE_FUNC: begin
                  if (!cfg.scan_mode && match) begin
                     word_a                 = make_simple(KIND_FOUND);
                     word_a.bus_number      = state.cur_bus;
                     word_a.device_number   = state.cur_device;
                     word_a.function_number = state.cur_function;
                     word_a.vendor_id       = ven;
                     word_a.product_id      = dev;
                  end else if (cfg.scan_mode && !absent) begin
                     word_a = make_request(state.cur_bus, state.cur_device,
                                           state.cur_function, OFFSET_CLASS);
                  end else begin
                     word_a = adv_rsp;
                  end
                  n_words = 2'd1;
               end
               PHASE_CLASS: begin
                  word_a                 = make_simple(KIND_REPORT);
                  word_a.bus_number      = state.cur_bus;
                  word_a.device_number   = state.cur_device;
                  word_a.function_number = state.cur_function;
                  word_a.vendor_id       = state.held_vendor;
                  word_a.product_id      = state.held_device;
                  word_a.class_code      = word.read_data[31:24];
                  word_a.subclass_code   = word.read_data[23:16];
                  word_b                 = adv_rsp;
                  n_words                = 2'd2;
               end
               default: begin
               end
            endcase
         end
      end
      word_a.device_count = count_next;
      word_b.device_count = count_next;
      word_a.last         = (n_words == 2'd1);
      word_b.last         = (n_words == 2'd2);
      push.count  = n_words;
      push.word_a = word_a;
      push.word_b = word_b;
   end

endmodule

`default_nettype wire

// ===== design/pcss_rsp_fifo.sv =====
// Result queue: takes up to two words per cycle, hands out one.
`default_nettype none

module pcss_rsp_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  pcss_pkg::push_type      push,
   output logic                    space_two,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output pcss_pkg::rsp_word_type  rsp_word
);
   import pcss_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_word_type     entries_ff [RSP_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_b;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entries_ff[rd_ptr_ff];
   assign space_two = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign wr_ptr_b  = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.word_a;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_b] <= push.word_b;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_two)
      else $error("push into queue without room for two words");

   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2 && !pop) |=> count_ff == $past(count_ff) + CNT_W'(2))
      else $error("double push not counted");

endmodule

`default_nettype wire

// ===== design/pci_config_space_scan_sequencer_unit.sv =====
// Top level of the PCI config space scan sequencer.
// Walks bus/device/function config space one dword read at a time. A start
// word (mode 0) restarts the scan and clears the count; each returned dword
// (mode 1) during a scan yields the next read request, or a report, found,
// not found or done word. Every input word is handled at accept: the scan
// state registers update and the results go into a four-word queue, so one
// input word per cycle is taken while the queue has two free words. A
// class-read response yields two result words (report, then the next request
// or done); since the result side drains at most one word per cycle, a run
// of those fills the queue and holds off input. Registers are written through
// the csr port, which is always ready; writes to index 3 are dropped.
`default_nettype none

module pci_config_space_scan_sequencer_unit #(
   parameter int NUM_BUSES       = pcss_pkg::NUM_BUSES_DEFAULT,
   parameter int DEVICES_PER_BUS = pcss_pkg::DEVICES_PER_BUS_DEFAULT,
   parameter int MULTI_FUNCTIONS = pcss_pkg::MULTI_FUNCTIONS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  pcss_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output pcss_pkg::rsp_word_type  rsp_word,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [1:0]               csr_index,
   input  wire [15:0]              csr_data
);
   import pcss_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   scan_state_type state_ff, state_in;
   push_type       push;
   logic           fire;
   logic           space_two;

   assign csr_ready = 1'b1;
   assign req_ready = space_two;
   assign fire      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCAN_MODE:     cfg_in.scan_mode     = csr_data[0];
            CSR_TARGET_VENDOR: cfg_in.target_vendor = csr_data;
            CSR_TARGET_DEVICE: cfg_in.target_device = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         state_ff <= '{phase: PHASE_IDLE, function_limit: 4'd1, default: '0};
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   pcss_step #(
      .NUM_BUSES       (NUM_BUSES),
      .DEVICES_PER_BUS (DEVICES_PER_BUS),
      .MULTI_FUNCTIONS (MULTI_FUNCTIONS)
   ) u_step (
      .fire       (fire),
      .word       (req_word),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .push       (push)
   );

   pcss_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_two (space_two),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.cur_device} < 6'(DEVICES_PER_BUS))
      else $error("device number past end of bus");

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.cur_function} < state_ff.function_limit)
      else $error("function number past function limit");

   assert property (@(posedge clock) disable iff (reset)
      (fire && req_word.mode == MODE_START) |=>
         state_ff.found_count == '0 && state_ff.phase == PHASE_PROBE)
      else $error("start did not restart the scan");

   assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff.phase == PHASE_IDLE && req_word.mode == MODE_DATA) |->
         push.count == 2'd0)
      else $error("result produced while idle");

endmodule

`default_nettype wire
